// ----- rtl/core/cel_pkg.sv -----
`default_nettype none
package cel_pkg;

  localparam int LOG_DEPTH_DEF = 8;

  localparam int CODE_W     = 8;
  localparam int ARG_W      = 16;
  localparam int REP_W      = 8;
  localparam int FILL_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [REP_W-1:0] REPEAT_MAX = '1;
  localparam logic [ARG_W-1:0] ARG_MAX    = '1;

  localparam logic [CODE_W-1:0] OVF_CODE_RST = CODE_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_OVF_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALTED   = 1'b1;

  typedef enum logic [0:0] {
    OP_LOG = 1'b0,
    OP_POP = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    STS_APPENDED  = 3'd0,
    STS_MERGED    = 3'd1,
    STS_OVF_CNT   = 3'd2,
    STS_REPLACED  = 3'd3,
    STS_HALTED    = 3'd4,
    STS_POPPED    = 3'd5,
    STS_POP_EMPTY = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    WR_NONE    = 3'd0,
    WR_MERGE   = 3'd1,
    WR_OVF_CNT = 3'd2,
    WR_APPEND  = 3'd3,
    WR_REPLACE = 3'd4,
    WR_POP     = 3'd5
  } wr_op_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ARG_W-1:0]  arg;
    logic [REP_W-1:0]  rep;
  } rec_t;

  typedef struct packed {
    logic    load;
    logic    scan_log;
    logic    scan_ovf;
    logic    run;
    logic    rd_head;
    wr_op_t  wr;
    logic    out_load;
    status_t status;
  } cel_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic empty;
    logic full;
    logic halted;
    logic out_free;
  } cel_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/cel_req_if.sv -----
`default_nettype none
interface cel_req_if import cel_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [CODE_W-1:0]   error_code;
  logic [ARG_W-1:0]    error_arg;

  modport source (output valid, opcode, error_code, error_arg, input ready);
  modport sink (input valid, opcode, error_code, error_arg, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cel_rsp_if.sv -----
`default_nettype none
interface cel_rsp_if import cel_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [CODE_W-1:0]   rec_code;
  logic [ARG_W-1:0]    rec_arg;
  logic [REP_W-1:0]    rec_repeats;
  logic [FILL_W-1:0]   fill_level;

  modport source (output valid, status, rec_code, rec_arg, rec_repeats, fill_level,
                  input ready);
  modport sink (input valid, status, rec_code, rec_arg, rec_repeats, fill_level,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cel_ctrl.sv -----
`default_nettype none
module cel_ctrl import cel_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_opcode,
  output logic           in_ready,
  input  wire cel_stat_t stat,
  output cel_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_OVF  = 5'b00100,
    S_POP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t  state, state_next;
  status_t status, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= STS_APPENDED;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd          = '0;
    cmd.wr       = WR_NONE;
    cmd.status   = status;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_opcode == OP_POP) begin
            if (stat.empty) begin
              status_next = STS_POP_EMPTY;
              state_next  = S_DONE;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = S_POP;
            end
          end else if (stat.halted) begin
            status_next = STS_HALTED;
            state_next  = S_DONE;
          end else begin
            cmd.scan_log = 1'b1;
            state_next   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.run = 1'b1;
        if (stat.hit) begin
          cmd.wr      = WR_MERGE;
          status_next = STS_MERGED;
          state_next  = S_DONE;
        end else if (stat.scan_done) begin
          if (stat.full) begin
            cmd.scan_ovf = 1'b1;
            state_next   = S_OVF;
          end else begin
            cmd.wr      = WR_APPEND;
            status_next = STS_APPENDED;
            state_next  = S_DONE;
          end
        end
      end
      S_OVF: begin
        cmd.run = 1'b1;
        if (stat.hit) begin
          cmd.wr      = WR_OVF_CNT;
          status_next = STS_OVF_CNT;
          state_next  = S_DONE;
        end else if (stat.scan_done) begin
          cmd.wr      = WR_REPLACE;
          status_next = STS_REPLACED;
          state_next  = S_DONE;
        end
      end
      S_POP: begin
        cmd.wr      = WR_POP;
        status_next = STS_POPPED;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/cel_dp.sv -----
`default_nettype none
module cel_dp import cel_pkg::*; #(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cel_cmd_t              cmd,
  output cel_stat_t                  stat,
  input  wire logic [CODE_W-1:0]     in_code,
  input  wire logic [ARG_W-1:0]      in_arg,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_status,
  output logic [CODE_W-1:0]          out_code,
  output logic [ARG_W-1:0]           out_arg,
  output logic [REP_W-1:0]           out_rep,
  output logic [FILL_W-1:0]          out_fill
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam logic [AW-1:0] LAST  = AW'(LOG_DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(LOG_DEPTH);

  rec_t mem [LOG_DEPTH];
  rec_t rdata;

  logic [CODE_W-1:0] code_q;
  logic [ARG_W-1:0]  arg_q;
  logic [CODE_W-1:0] ovf_code;
  logic              halted;

  logic [AW-1:0] wr_ptr, rd_ptr, scan_ptr, chk_ptr;
  logic [CW-1:0] count, scan_n, limit;
  logic          ovf_mode, chk_vld;

  logic          issue, re, we;
  logic [AW-1:0] raddr, waddr;
  rec_t          wdata;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_code <= OVF_CODE_RST;
      halted   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OVF_CODE: ovf_code <= cfg_data[CODE_W-1:0];
        CFG_HALTED:   halted   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_q <= in_code;
      arg_q  <= in_arg;
    end
  end

  assign issue = scan_n != limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else if (cmd.scan_log || cmd.scan_ovf) begin
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= cmd.run && issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_log) begin
      scan_ptr <= rd_ptr;
      scan_n   <= '0;
      limit    <= count;
      ovf_mode <= 1'b0;
    end else if (cmd.scan_ovf) begin
      scan_ptr <= '0;
      scan_n   <= '0;
      limit    <= FULLC;
      ovf_mode <= 1'b1;
    end else if (cmd.run) begin
      chk_ptr <= scan_ptr;
      if (issue) begin
        scan_ptr <= adv(scan_ptr);
        scan_n   <= scan_n + CW'(1);
      end
    end
  end

  assign re    = cmd.run || cmd.rd_head;
  assign raddr = cmd.rd_head ? rd_ptr : scan_ptr;

  always_comb begin
    we    = 1'b1;
    waddr = chk_ptr;
    wdata = rdata;
    case (cmd.wr)
      WR_MERGE: begin
        if (rdata.rep != REPEAT_MAX) wdata.rep = rdata.rep + REP_W'(1);
      end
      WR_OVF_CNT: begin
        if (rdata.arg != ARG_MAX) wdata.arg = rdata.arg + ARG_W'(1);
      end
      WR_APPEND: begin
        waddr = wr_ptr;
        wdata = '{code: code_q, arg: arg_q, rep: '0};
      end
      WR_REPLACE: begin
        waddr = (wr_ptr == '0) ? LAST : wr_ptr - AW'(1);
        wdata = '{code: ovf_code, arg: ARG_W'(1), rep: REP_W'(1)};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (cmd.wr)
        WR_APPEND: begin
          wr_ptr <= adv(wr_ptr);
          count  <= count + CW'(1);
        end
        WR_POP: begin
          rd_ptr <= adv(rd_ptr);
          count  <= count - CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.status;
      out_fill   <= FILL_W'(count);
      if (cmd.status == STS_POPPED) begin
        out_code <= rdata.code;
        out_arg  <= rdata.arg;
        out_rep  <= rdata.rep;
      end else begin
        out_code <= '0;
        out_arg  <= '0;
        out_rep  <= '0;
      end
    end
  end

  always_comb begin
    stat.hit = chk_vld && (ovf_mode ? (rdata.code == ovf_code)
                                    : (rdata.code == code_q && rdata.arg == arg_q));
    stat.scan_done = !chk_vld && !issue;
    stat.empty     = count == '0;
    stat.full      = count == FULLC;
    stat.halted    = halted;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ----- rtl/core/coalescing_error_log_ring_top.sv -----
`default_nettype none
// Pop: the head is read and the read pointer advanced, then the result is loaded.
// Log: the ring is scanned for a matching entry (ending early on a merge), then written;
// a full ring with no match then scans all entries for the overflow code, one per cycle.
// One item at a time: the next item can be accepted in the cycle after its result is loaded;
// an untaken result holds the next item in its final state until the output slot frees.
// Reset clears pointers, count, control and config; record memory is not cleared.
module coalescing_error_log_ring_top import cel_pkg::*; #(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  cel_req_if.sink                    req,
  cel_rsp_if.source                  rsp,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cel_cmd_t  cmd;
  cel_stat_t stat;

  cel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_opcode (req.opcode),
    .in_ready  (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cel_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_code    (req.error_code),
    .in_arg     (req.error_arg),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_code   (rsp.rec_code),
    .out_arg    (rsp.rec_arg),
    .out_rep    (rsp.rec_repeats),
    .out_fill   (rsp.fill_level)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("item accepted while another is in flight");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr == WR_APPEND |-> !stat.full)
    else $error("append into a full ring");

  a_pop_held: assert property (@(posedge clk) disable iff (rst)
    cmd.wr == WR_POP |-> !stat.empty)
    else $error("pop from an empty ring");
`endif

endmodule
`default_nettype wire
